FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the formatter datapath, bafmt_dp. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BAF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BAF_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BAF_ASSERT(label, clk, rst_n, prop, msg)
`define BAF_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

FILE: rtl/core/bafmt_pkg.sv
// ----------------------------------------------------------------------------
// bafmt_pkg
// Types, format codes, character codes and constant tables for the
// binary to ASCII number formatter.
// ----------------------------------------------------------------------------
package bafmt_pkg;

    localparam logic [2:0] KIND_U16  = 3'd0;
    localparam logic [2:0] KIND_U8   = 3'd1;
    localparam logic [2:0] KIND_S16  = 3'd2;
    localparam logic [2:0] KIND_U32  = 3'd3;
    localparam logic [2:0] KIND_HEX8 = 3'd4;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;

    localparam logic [3:0] EXP_U16 = 4'd4;
    localparam logic [3:0] EXP_U8  = 4'd2;
    localparam logic [3:0] EXP_U32 = 4'd9;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_CALC,
        ST_EMIT,
        ST_HEX_HI,
        ST_HEX_LO
    } state_t;

    typedef struct packed {
        logic load;
        logic emit_sign;
        logic calc;
        logic emit_dig;
        logic skip_dig;
        logic emit_hex_hi;
        logic emit_hex_lo;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic step_last;
        logic exp_zero;
        logic skip;
    } dp_sts_t;

    function automatic logic [35:0] pow10_f(input logic [3:0] e);
        logic [35:0] r;
        case (e)
            4'd0:    r = 36'd1;
            4'd1:    r = 36'd10;
            4'd2:    r = 36'd100;
            4'd3:    r = 36'd1000;
            4'd4:    r = 36'd10000;
            4'd5:    r = 36'd100000;
            4'd6:    r = 36'd1000000;
            4'd7:    r = 36'd10000000;
            4'd8:    r = 36'd100000000;
            4'd9:    r = 36'd1000000000;
            default: r = 36'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] hex_char_f(input logic [3:0] n);
        logic [6:0] r;
        if (n < 4'd10)
        begin
            r = CH_ZERO + {3'b000, n};
        end
        else
        begin
            r = CH_UPPER_A + {3'b000, n - 4'd10};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/bafmt_dp.sv
// ----------------------------------------------------------------------------
// bafmt_dp
// Datapath: remainder register with a restoring compare-subtract against
// scaled powers of ten, digit and sign flags, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bafmt_dp
    import bafmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [31:0] rem_reg, rem_next;
    logic [3:0]  exp_reg, exp_next;
    logic [1:0]  step_reg, step_next;
    logic [3:0]  digit_reg, digit_next;
    logic        seen_reg, seen_next;
    logic        neg_reg, neg_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic [35:0] trial;
    logic [35:0] rem_ext;
    logic [35:0] diff;
    logic        fits;
    logic [16:0] mag;
    logic        out_free;
    logic [3:0]  emit_vec;

    assign rem_ext = {4'b0000, rem_reg};
    assign trial   = pow10_f(exp_reg) << (2'd3 - step_reg);
    assign fits    = (rem_ext >= trial);
    assign diff    = rem_ext - trial;
    assign mag     = 17'h10000 - {1'b0, in_data.value[15:0]};
    assign out_free = !out_valid_reg || out_ready;
    assign emit_vec = {cmd.emit_sign, cmd.emit_dig, cmd.emit_hex_hi, cmd.emit_hex_lo};

    assign sts.out_free  = out_free;
    assign sts.step_last = (step_reg == 2'd3);
    assign sts.exp_zero  = (exp_reg == 4'd0);
    assign sts.skip      = (digit_reg == 4'd0) && !seen_reg && (exp_reg != 4'd0);

    always_comb
    begin
        rem_next   = rem_reg;
        exp_next   = exp_reg;
        step_next  = step_reg;
        digit_next = digit_reg;
        seen_next  = seen_reg;
        neg_next   = neg_reg;

        if (cmd.load)
        begin
            step_next  = 2'd0;
            digit_next = 4'd0;
            seen_next  = 1'b1;
            neg_next   = in_data.value[15];
            case (in_data.kind)
                KIND_U16:
                begin
                    rem_next = {16'h0000, in_data.value[15:0]};
                    exp_next = EXP_U16;
                end
                KIND_U8:
                begin
                    rem_next = {24'h000000, in_data.value[7:0]};
                    exp_next = EXP_U8;
                end
                KIND_S16:
                begin
                    if (in_data.value[15])
                    begin
                        rem_next = {15'h0000, mag};
                    end
                    else
                    begin
                        rem_next = {16'h0000, in_data.value[15:0]};
                    end
                    exp_next = EXP_U16;
                end
                KIND_U32:
                begin
                    rem_next  = in_data.value;
                    exp_next  = EXP_U32;
                    seen_next = 1'b0;
                end
                default:
                begin
                    rem_next = {24'h000000, in_data.value[7:0]};
                    exp_next = 4'd0;
                end
            endcase
        end
        else if (cmd.calc)
        begin
            step_next = step_reg + 2'd1;
            if (fits)
            begin
                rem_next   = diff[31:0];
                digit_next = digit_reg | (4'b1000 >> step_reg);
            end
        end
        else if (cmd.emit_dig || cmd.skip_dig)
        begin
            if (cmd.emit_dig)
            begin
                seen_next = 1'b1;
            end
            if (exp_reg != 4'd0)
            begin
                exp_next = exp_reg - 4'd1;
            end
            step_next  = 2'd0;
            digit_next = 4'd0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit_sign)
        begin
            out_valid_next          = 1'b1;
            out_data_next.character = neg_reg ? CH_MINUS : CH_PLUS;
            out_data_next.last      = 1'b0;
        end
        else if (cmd.emit_dig)
        begin
            out_valid_next          = 1'b1;
            out_data_next.character = CH_ZERO + {3'b000, digit_reg};
            out_data_next.last      = (exp_reg == 4'd0);
        end
        else if (cmd.emit_hex_hi)
        begin
            out_valid_next          = 1'b1;
            out_data_next.character = hex_char_f(rem_reg[7:4]);
            out_data_next.last      = 1'b0;
        end
        else if (cmd.emit_hex_lo)
        begin
            out_valid_next          = 1'b1;
            out_data_next.character = hex_char_f(rem_reg[3:0]);
            out_data_next.last      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        exp_reg      <= exp_next;
        step_reg     <= step_next;
        digit_reg    <= digit_next;
        seen_reg     <= seen_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BAF_ASSERT(a_emit_into_free, clk, rst_n, (emit_vec != 4'd0) |-> out_free, "Character loaded while the output register holds a pending transaction.")
    `BAF_ASSERT(a_single_emit, clk, rst_n, $onehot0(emit_vec), "More than one character source selected in one cycle.")
    `BAF_ASSERT_NEVER(a_digit_range, clk, rst_n, cmd.emit_dig && (digit_reg > 4'd9), "Decimal digit above nine after the subtract steps.")

endmodule

FILE: rtl/core/bafmt_ctrl.sv
// ----------------------------------------------------------------------------
// bafmt_ctrl
// Controller: sequences the sign, the subtract steps of each decimal digit,
// leading-zero suppression and the hex digits.
// ----------------------------------------------------------------------------
module bafmt_ctrl
    import bafmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] in_kind,
    output logic       in_ready,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_kind)
                        KIND_U16, KIND_U8, KIND_U32: state_next = ST_CALC;
                        KIND_S16:                    state_next = ST_SIGN;
                        KIND_HEX8:                   state_next = ST_HEX_HI;
                        default:                     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (sts.step_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.skip)
                begin
                    state_next = ST_CALC;
                end
                else if (sts.out_free)
                begin
                    state_next = sts.exp_zero ? ST_IDLE : ST_CALC;
                end
            end
            ST_HEX_HI:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_HEX_LO;
                end
            end
            ST_HEX_LO:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = sts.out_free;
            end
            ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.skip_dig = sts.skip;
                cmd.emit_dig = !sts.skip && sts.out_free;
            end
            ST_HEX_HI:
            begin
                cmd.emit_hex_hi = sts.out_free;
            end
            ST_HEX_LO:
            begin
                cmd.emit_hex_lo = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/binary_to_ascii_number_formatter.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_number_formatter
// Formats one number per input transaction as ASCII characters, one output
// transaction per character, with last set on the final character.
//
//   Channel   Signals                        Direction
//   input     in_valid, in_ready, in_data    number and format kind in
//   output    out_valid, out_ready, out_data one character and last out
//
// Each decimal digit takes four compare-subtract steps on the remainder
// register, then one step to issue the digit.
// One number is worked on at a time; the next is accepted once the final
// character sits in the output register. Output stalls hold the controller.
// Reset clears the state machine and the output valid flag.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_formatter
    import bafmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    bafmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_data.kind),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bafmt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: dv/binary_to_ascii_number_formatter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number formatter checker
// Watches both channels of the number formatter. For every accepted number
// it works out the ASCII characters the block must send and queues them.
// Every accepted character is compared with the oldest queued one. The
// failure count and the number of characters still owed go to the top.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_formatter_checker
    import bafmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        error_count,
    output int        pending_count
);

    out_item_t expected_chars[$];

    function automatic void queue_char(logic [6:0] code);
        out_item_t item;
        item.character = code;
        item.last      = 1'b0;
        expected_chars.push_back(item);
    endfunction

    function automatic void queue_decimal(logic [31:0] number, int digits);
        logic [31:0] rest;
        logic [31:0] scale;
        logic [31:0] digit;
        int          i;
        int          j;
        rest = number;
        for (i = digits - 1; i >= 0; i--)
        begin
            scale = 32'd1;
            for (j = 0; j < i; j++)
            begin
                scale = scale * 32'd10;
            end
            digit = rest / scale;
            rest  = rest % scale;
            queue_char(CH_ZERO + digit[6:0]);
        end
    endfunction

    function automatic void queue_hex_digit(logic [3:0] nibble);
        if (nibble < 4'd10)
        begin
            queue_char(CH_ZERO + {3'b000, nibble});
        end
        else
        begin
            queue_char(CH_UPPER_A + {3'b000, nibble} - 7'd10);
        end
    endfunction

    function automatic void predict_characters(in_item_t item);
        int          before_count;
        int          digits;
        longint      limit;
        logic [15:0] half;
        logic [16:0] magnitude;
        before_count = expected_chars.size();
        half = item.value[15:0];
        case (item.kind)
            KIND_U16:
            begin
                queue_decimal({16'd0, half}, 5);
            end
            KIND_U8:
            begin
                queue_decimal({24'd0, item.value[7:0]}, 3);
            end
            KIND_S16:
            begin
                if (!half[15])
                begin
                    queue_char(CH_PLUS);
                    queue_decimal({16'd0, half}, 5);
                end
                else
                begin
                    magnitude = 17'h10000 - {1'b0, half};
                    queue_char(CH_MINUS);
                    queue_decimal({15'd0, magnitude}, 5);
                end
            end
            KIND_U32:
            begin
                digits = 1;
                limit  = 10;
                while (digits < 10 && longint'(item.value) >= limit)
                begin
                    digits++;
                    limit = limit * 10;
                end
                queue_decimal(item.value, digits);
            end
            KIND_HEX8:
            begin
                queue_hex_digit(item.value[7:4]);
                queue_hex_digit(item.value[3:0]);
            end
            default:
            begin
            end
        endcase
        if (expected_chars.size() > before_count)
        begin
            expected_chars[expected_chars.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t wanted;
        if (!rst_n)
        begin
            expected_chars.delete();
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_characters(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected character %h last %b", $time,
                             out_data.character, out_data.last);
                    error_count <= error_count + 1;
                end
                else
                begin
                    wanted = expected_chars.pop_front();
                    if (out_data.character !== wanted.character ||
                        out_data.last !== wanted.last)
                    begin
                        $display("%0t: expected character %h last %b, got %h last %b",
                                 $time, wanted.character, wanted.last,
                                 out_data.character, out_data.last);
                        error_count <= error_count + 1;
                    end
                end
            end
            pending_count <= expected_chars.size();
        end
    end

endmodule

FILE: dv/binary_to_ascii_number_formatter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number formatter testbench
// Sends directed and random numbers of every format kind to the formatter,
// with random idle cycles on both channels, and leaves the checking of the
// returned characters to the checker module.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_formatter_test;
    import bafmt_pkg::*;

    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    int        error_count;
    int        pending_count;
    int        sender_idle_pct = 15;
    int        receiver_idle_pct = 46;

    binary_to_ascii_number_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    binary_to_ascii_number_formatter_checker number_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("binary_to_ascii_number_formatter_test: done, errors");
        $finish;
    end

    task automatic send_number(logic [2:0] kind, logic [31:0] value);
        in_item_t item;
        item.kind  = kind;
        item.value = value;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic wait_for_characters();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_count != 0);
    endtask

    task automatic send_random_numbers(int count);
        logic [2:0]  kind;
        logic [31:0] value;
        logic [31:0] power;
        int          exponent;
        int          sent;
        int          i;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                kind = 3'($urandom_range(KIND_SPARE_7, KIND_SPARE_5));
            end
            else
            begin
                kind = 3'($urandom_range(KIND_HEX8, KIND_U16));
                sent++;
            end
            case ($urandom_range(3))
                0:
                begin
                    value = $urandom;
                end
                1:
                begin
                    value = {$urandom} & ~(32'hFFFF_FFFF << $urandom_range(32, 1));
                end
                2:
                begin
                    power    = 32'd1;
                    exponent = $urandom_range(9);
                    for (i = 0; i < exponent; i++)
                    begin
                        power = power * 32'd10;
                    end
                    value = power + $urandom_range(2) - 32'd1;
                end
                default:
                begin
                    value = {16'($urandom), 16'h8000 ^ 16'($urandom_range(3))};
                    if ($urandom_range(1) == 1)
                    begin
                        value = ~value;
                    end
                end
            endcase
            send_number(kind, value);
        end
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_number(KIND_U16, 32'h0000_0000);
        send_number(KIND_U16, 32'h0000_FFFF);
        send_number(KIND_U16, 32'hFFFF_0000);
        send_number(KIND_U8, 32'h0000_0000);
        send_number(KIND_U8, 32'h0000_00FF);
        send_number(KIND_U8, 32'hABCD_EF80);
        send_number(KIND_S16, 32'h0000_0000);
        send_number(KIND_S16, 32'h0000_7FFF);
        send_number(KIND_S16, 32'h0000_8000);
        send_number(KIND_S16, 32'h0000_FFFF);
        send_number(KIND_S16, 32'h1234_8001);
        send_number(KIND_U32, 32'd0);
        send_number(KIND_U32, 32'd1);
        send_number(KIND_U32, 32'd10);
        send_number(KIND_U32, 32'd999_999_999);
        send_number(KIND_U32, 32'd1_000_000_000);
        send_number(KIND_U32, 32'h7FFF_FFFF);
        send_number(KIND_U32, 32'h8000_0000);
        send_number(KIND_U32, 32'hFFFF_FFFF);
        send_number(KIND_HEX8, 32'h0000_0000);
        send_number(KIND_HEX8, 32'hFFFF_FFFF);
        send_number(KIND_HEX8, 32'h0000_005A);
        send_number(KIND_HEX8, 32'h1234_56A5);
        send_number(KIND_SPARE_5, 32'h0000_0001);
        send_number(KIND_SPARE_6, 32'hFFFF_FFFF);
        send_number(KIND_SPARE_7, 32'h8000_0000);
        wait_for_characters();

        send_random_numbers(55);
        wait_for_characters();

        sender_idle_pct   = 46;
        receiver_idle_pct = 15;
        send_random_numbers(55);
        wait_for_characters();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_random_numbers(55);
        wait_for_characters();

        repeat (100) @(posedge clk);
        if (error_count == 0)
        begin
            $display("binary_to_ascii_number_formatter_test: done, clean");
        end
        else
        begin
            $display("binary_to_ascii_number_formatter_test: done, errors");
        end
        $finish;
    end

endmodule
